### src/char_lcd_nibble_write_sequencer_core_macros.svh
// Assertion macros used by the sequencer core.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define LCDNWS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define LCDNWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCDNWS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define LCDNWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### src/lcdnws_pkg.sv
`default_nettype none
package lcdnws_pkg;

    // Operation codes of an incoming request.
    localparam logic [1:0] OP_CMD    = 2'd0;
    localparam logic [1:0] OP_CHAR   = 2'd1;
    localparam logic [1:0] OP_INIT   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_IDX_W      = 1;
    localparam logic [0:0] CFG_DISPLAY_ON = 1'd0;
    localparam logic [0:0] CFG_CLEAR      = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [7:0] DISPLAY_ON_RESET = 8'd12;
    localparam logic [7:0] CLEAR_RESET      = 8'd1;

    // Hold times in delay units.
    localparam int          HOLD_W    = 13;
    localparam logic [12:0] HOLD_BYTE = 13'd200;
    localparam logic [12:0] HOLD_NIB  = 13'd201;
    localparam logic [12:0] HOLD_EDGE = 13'd1;
    localparam logic [12:0] HOLD_NONE = 13'd0;
    localparam logic [12:0] HOLD_WAIT = 13'd5000;
    localparam logic [12:0] HOLD_WAKE = 13'd1000;

    // Classified request as it travels through the queue.
    typedef struct packed {
        logic       is_init;
        logic       sel;
        logic [7:0] value;
    } t_req;

    // Head of the request queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_req req;
    } t_qhead;

    // One pin setting.
    typedef struct packed {
        logic        select_line;
        logic        rw_line;
        logic        enable_line;
        logic [3:0]  data_nibble;
        logic [12:0] hold_units;
        logic        last;
    } t_setting;

endpackage
`default_nettype wire

### src/lcdnws_front.sv
`default_nettype none
module lcdnws_front #(
    parameter int QDEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [1:0]          i_operation,
    input  wire  [7:0]          i_byte_value,
    output lcdnws_pkg::t_qhead  o_head,
    input  wire                 i_pop
);
    import lcdnws_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_req          r_mem [QDEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic          accept;
    logic          push;
    logic          pop;
    t_req          new_req;

    // A request is taken whenever the queue has room.
    assign o_in_ready = (r_count != CW'(QDEPTH));
    assign accept     = i_in_valid && o_in_ready;
    // The unused operation code is taken and dropped here.
    assign push       = accept && (i_operation != OP_UNUSED);
    assign pop        = i_pop && (r_count != '0);

    // Classify the request for the back end.
    always_comb begin
        new_req.is_init = (i_operation == OP_INIT);
        new_req.sel     = (i_operation == OP_CHAR);
        new_req.value   = i_byte_value;
    end

    // Pointer wrap for any queue depth.
    assign n_wr = (r_wr == PW'(QDEPTH - 1)) ? '0 : r_wr + PW'(1);
    assign n_rd = (r_rd == PW'(QDEPTH - 1)) ? '0 : r_rd + PW'(1);

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= new_req;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= n_wr;
            end
            if (pop) begin
                r_rd <= n_rd;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_mem[r_rd];

endmodule
`default_nettype wire

### src/lcdnws_back.sv
`default_nettype none
module lcdnws_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  lcdnws_pkg::t_qhead    i_head,
    output logic                  o_pop,
    input  wire  [7:0]            i_display_on,
    input  wire  [7:0]            i_clear,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output lcdnws_pkg::t_setting  o_setting
);
    import lcdnws_pkg::*;

    // Sub-steps of one byte write.
    localparam logic [2:0] BS_SEL   = 3'd0;
    localparam logic [2:0] BS_HI    = 3'd1;
    localparam logic [2:0] BS_HI_EN = 3'd2;
    localparam logic [2:0] BS_LO    = 3'd3;
    localparam logic [2:0] BS_LO_EN = 3'd4;
    localparam logic [2:0] BS_END   = 3'd5;

    // Steps of the initialization before its two command writes.
    localparam logic [4:0] IS_WAIT     = 5'd0;
    localparam logic [4:0] IS_W0_NIB   = 5'd1;
    localparam logic [4:0] IS_W0_HI    = 5'd2;
    localparam logic [4:0] IS_W0_LO    = 5'd3;
    localparam logic [4:0] IS_W1_NIB   = 5'd4;
    localparam logic [4:0] IS_W1_HI    = 5'd5;
    localparam logic [4:0] IS_W1_LO    = 5'd6;
    localparam logic [4:0] IS_W2_NIB   = 5'd7;
    localparam logic [4:0] IS_W2_HI    = 5'd8;
    localparam logic [4:0] IS_W2_LO    = 5'd9;
    localparam logic [4:0] IS_MODE_NIB = 5'd10;
    localparam logic [4:0] IS_MODE_HI  = 5'd11;
    localparam logic [4:0] IS_MODE_LO  = 5'd12;
    localparam logic [4:0] IS_BYTE0    = 5'd13;
    localparam logic [4:0] IS_BYTE1    = 5'd19;
    localparam logic [4:0] IS_FINAL    = 5'd24;

    localparam logic [3:0] WAKE_BITS = 4'b0011;
    localparam logic [3:0] MODE_KEEP = 4'b1100;
    localparam logic [3:0] MODE_BITS = 4'b0010;

    logic [4:0] r_step;
    logic [3:0] r_data;
    logic       r_sel;
    logic       r_out_valid;
    t_setting   r_setting;

    logic       advance;
    logic       in_byte;
    logic [2:0] bsub;
    logic [7:0] bval;
    logic       bsel;
    logic       blast;
    t_setting   n_setting;

    // One setting leaves per cycle while the output register can take it.
    assign advance = i_head.valid && (!r_out_valid || i_out_ready);

    // Map the step onto a byte write where one is in progress.
    always_comb begin
        in_byte = 1'b1;
        bsub    = r_step[2:0];
        bval    = i_head.req.value;
        bsel    = i_head.req.sel;
        blast   = 1'b1;
        if (i_head.req.is_init) begin
            bsel  = 1'b0;
            blast = 1'b0;
            if (r_step >= IS_BYTE1) begin
                bsub  = 3'(r_step - IS_BYTE1);
                bval  = i_clear;
                blast = (r_step == IS_FINAL);
            end else if (r_step >= IS_BYTE0) begin
                bsub = 3'(r_step - IS_BYTE0);
                bval = i_display_on;
            end else begin
                in_byte = 1'b0;
            end
        end
    end

    // Build the pin setting of this step.
    always_comb begin
        n_setting.select_line = r_sel;
        n_setting.rw_line     = 1'b0;
        n_setting.enable_line = 1'b0;
        n_setting.data_nibble = r_data;
        n_setting.hold_units  = HOLD_NONE;
        n_setting.last        = 1'b0;
        if (in_byte) begin
            case (bsub)
                BS_SEL: begin
                    n_setting.select_line = bsel;
                    n_setting.hold_units  = HOLD_BYTE;
                end
                BS_HI: begin
                    n_setting.data_nibble = bval[7:4];
                    n_setting.hold_units  = HOLD_NIB;
                end
                BS_HI_EN, BS_LO_EN: begin
                    n_setting.enable_line = 1'b1;
                    n_setting.hold_units  = HOLD_EDGE;
                end
                BS_LO: begin
                    n_setting.data_nibble = bval[3:0];
                    n_setting.hold_units  = HOLD_NIB;
                end
                BS_END: begin
                    n_setting.last = blast;
                end
                default: begin
                    n_setting.hold_units = HOLD_NONE;
                end
            endcase
        end else begin
            case (r_step)
                IS_WAIT: begin
                    n_setting.select_line = 1'b0;
                    n_setting.hold_units  = HOLD_WAIT;
                end
                IS_W0_NIB, IS_W1_NIB, IS_W2_NIB: begin
                    n_setting.data_nibble = r_data | WAKE_BITS;
                    n_setting.hold_units  = HOLD_EDGE;
                end
                IS_W0_HI, IS_W1_HI, IS_W2_HI, IS_MODE_HI: begin
                    n_setting.enable_line = 1'b1;
                    n_setting.hold_units  = HOLD_EDGE;
                end
                IS_W0_LO, IS_W1_LO, IS_W2_LO: begin
                    n_setting.hold_units = HOLD_WAKE;
                end
                IS_MODE_NIB: begin
                    n_setting.data_nibble = (r_data & MODE_KEEP) | MODE_BITS;
                    n_setting.hold_units  = HOLD_EDGE;
                end
                IS_MODE_LO: begin
                    n_setting.hold_units = HOLD_NONE;
                end
                default: begin
                    n_setting.hold_units = HOLD_NONE;
                end
            endcase
        end
    end

    // The request leaves the queue with its final setting.
    assign o_pop = advance && n_setting.last;

    // Step counter, kept pin levels and output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_data      <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_data      <= n_setting.data_nibble;
            r_sel       <= n_setting.select_line;
            r_step      <= n_setting.last ? '0 : r_step + 5'd1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_setting <= n_setting;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_setting   = r_setting;

endmodule
`default_nettype wire

### src/char_lcd_nibble_write_sequencer_core.sv
`default_nettype none
// Four-bit character LCD write sequencer. A command or character request turns
// into six pin settings and an initialize request into 25, each leaving at one
// setting per cycle from the back-end step counter while the output register
// is free. A queue of QDEPTH classified requests lets the input side keep
// taking requests while settings are still going out; operation code 3 is
// taken and discarded without any setting. Hold times are in delay units for
// a downstream pin timer, not in clock cycles.
module char_lcd_nibble_write_sequencer_core #(
    parameter int QDEPTH = 2
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [1:0]                   i_operation,
    input  wire  [7:0]                   i_byte_value,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_select_line,
    output logic                         o_rw_line,
    output logic                         o_enable_line,
    output logic [3:0]                   o_data_nibble,
    output logic [12:0]                  o_hold_units,
    output logic                         o_last,
    input  wire                          i_cfg_we,
    input  wire  [lcdnws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [7:0]                   i_cfg_data
);
    import lcdnws_pkg::*;

`include "char_lcd_nibble_write_sequencer_core_macros.svh"

    logic [7:0] r_display_on;
    logic [7:0] r_clear;
    t_qhead     head;
    logic       pop;
    t_setting   setting;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_on <= DISPLAY_ON_RESET;
            r_clear      <= CLEAR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DISPLAY_ON: r_display_on <= i_cfg_data;
                CFG_CLEAR:      r_clear      <= i_cfg_data;
                default:        r_clear      <= r_clear;
            endcase
        end
    end

    // Request intake and queue.
    lcdnws_front #(
        .QDEPTH(QDEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_byte_value (i_byte_value),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Pin setting sequencer.
    lcdnws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_display_on (r_display_on),
        .i_clear      (r_clear),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_setting    (setting)
    );

    assign o_select_line = setting.select_line;
    assign o_rw_line     = setting.rw_line;
    assign o_enable_line = setting.enable_line;
    assign o_data_nibble = setting.data_nibble;
    assign o_hold_units  = setting.hold_units;
    assign o_last        = setting.last;

    // A request never ends with the enable strobe high, and its end holds nothing.
    `LCDNWS_ASSERT_SAME(a_last_enable_low, i_clk, i_rst_n, o_out_valid && o_enable_line, !o_last, "final setting with enable high")
    `LCDNWS_ASSERT_SAME(a_last_hold_zero, i_clk, i_rst_n, o_out_valid && o_last, o_hold_units == HOLD_NONE, "final setting with nonzero hold")
    // Settings of one request follow each other without a gap.
    `LCDNWS_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last, o_out_valid, "gap inside a request")

endmodule
`default_nettype wire
